[rtl/tfn_pkg.sv]
// Shared types and constants for the triangle face normal block.
`timescale 1ns / 1ps
package tfn_pkg;

    localparam int COORD_W  = 24;
    localparam int DIFF_W   = 25;
    localparam int CROSS_W  = 51;
    localparam int MAG_W    = 30;
    localparam int SUM_W    = 62;
    localparam int LEN_W    = 31;
    localparam int NORMAL_W = 16;
    localparam int MUL_W    = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FACE  = 1'b1;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_DEGEN  = 2'd1;
    localparam logic [1:0] STATUS_RANGE  = 2'd2;
    localparam logic [1:0] STATUS_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_LAT,
        ST_MUL,
        ST_MAG,
        ST_MAX,
        ST_NORM,
        ST_SQR,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } tfn_state_t;

endpackage

[rtl/tfn_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module tfn_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

[rtl/tfn_mul.sv]
// Registered signed multiplier shared by the cross product and the squares.
`timescale 1ns / 1ps
module tfn_mul
    import tfn_pkg::*;
(
    input  logic                      aclk,
    input  logic signed [MUL_W-1:0]   a,
    input  logic signed [MUL_W-1:0]   b,
    output logic signed [2*MUL_W-1:0] p_reg
);

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

endmodule

[rtl/tfn_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module tfn_sqrt
    import tfn_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] sum,
    output logic             busy,
    output logic             done,
    output logic [LEN_W-1:0] root
);

    logic             busy_reg;
    logic             done_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W:0]   root_reg;
    logic [SUM_W-1:0] bit_reg;
    logic [SUM_W:0]   cand;
    logic             ge;

    assign cand = root_reg + {1'b0, bit_reg};
    assign ge   = {1'b0, rem_reg} >= cand;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && start) begin
            rem_reg  <= sum;
            root_reg <= '0;
            bit_reg  <= SUM_W'(1) << (SUM_W - 2);
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg  <= rem_reg - cand[SUM_W-1:0];
                root_reg <= (root_reg >> 1) + {1'b0, bit_reg};
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg[LEN_W-1:0];

endmodule

[rtl/tfn_div.sv]
// Restoring divider that scales one magnitude by the length and packs it to Q1.F.
`timescale 1ns / 1ps
module tfn_div
    import tfn_pkg::*;
#(
    parameter int FRAC = 14
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [MAG_W-1:0]           mag,
    input  logic [LEN_W-1:0]           len,
    input  logic                       neg,
    output logic                       busy,
    output logic                       done,
    output logic signed [NORMAL_W-1:0] normal
);

    localparam int NW = MAG_W + FRAC + 1;
    localparam int QB = FRAC + 2;
    localparam int CW = $clog2(QB + 1);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [QB-1:0]    qr_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NW-1:0]    num;
    logic [LEN_W:0]   trial;
    logic             ge;
    logic [NORMAL_W:0] sat;
    logic [NORMAL_W:0] sgn;

    // Rounded numerator; the quotient is known to fit in QB bits
    assign num   = (NW'(mag) << FRAC) + NW'(len >> 1);
    assign trial = {rem_reg, qr_reg[QB-1]};
    assign ge    = trial >= {1'b0, len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(QB - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && start) begin
            rem_reg <= LEN_W'(num[NW-1:QB]);
            qr_reg  <= num[QB-1:0];
            len_reg <= len;
            neg_reg <= neg;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? LEN_W'(trial - {1'b0, len_reg}) : LEN_W'(trial);
            qr_reg  <= {qr_reg[QB-2:0], ge};
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_comb begin
        if (33'(qr_reg) > 33'd32768) begin
            sat = 17'd32768;
        end else begin
            sat = 17'(qr_reg);
        end
        if (neg_reg) begin
            sgn = -sat;
        end else if (sat == 17'd32768) begin
            sgn = 17'd32767;
        end else begin
            sgn = sat;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign normal = sgn[NORMAL_W-1:0];

endmodule

[rtl/triangle_face_normal.sv]
// Top level: vertex store and face normal sequencer.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | op, vertex_slot, coord_x/y/z, index_a/b/c
//  m_      | out       | m_valid / m_ready  | normal_x/y/z, status
//
// A vertex write or a rejected face goes from idle straight to the done state.
// A face is normalised by at most 29 single-bit shifts; the bit-serial square
// root and the three divides dominate its run time.
// One item is worked at a time; a finished result waits in the output register
// while the next item is taken. Reset is synchronous; the store is not cleared.
`timescale 1ns / 1ps
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int VERTEX_DEPTH     = 1024,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [9:0]                 s_vertex_slot,
    input  logic signed [COORD_W-1:0]  s_coord_x,
    input  logic signed [COORD_W-1:0]  s_coord_y,
    input  logic signed [COORD_W-1:0]  s_coord_z,
    input  logic [15:0]                s_index_a,
    input  logic [15:0]                s_index_b,
    input  logic [15:0]                s_index_c,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [NORMAL_W-1:0] m_normal_x,
    output logic signed [NORMAL_W-1:0] m_normal_y,
    output logic signed [NORMAL_W-1:0] m_normal_z,
    output logic [1:0]                 m_status
);

    localparam int AW = $clog2(VERTEX_DEPTH);

    tfn_state_t state_reg, state_next;

    logic                       s_acc;
    logic                       slot_ok;
    logic                       idx_bad;
    logic [AW-1:0]              ia_reg, ib_reg, ic_reg;
    logic [AW-1:0]              rd_addr;
    logic [3*COORD_W-1:0]       rdata;
    logic signed [COORD_W-1:0]  rd_x, rd_y, rd_z;
    logic signed [COORD_W-1:0]  ax_reg, ay_reg, az_reg;
    logic signed [DIFF_W-1:0]   ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [CROSS_W-1:0]  c_reg [3];
    logic [CROSS_W-1:0]         mag_reg [3];
    logic                       neg_reg [3];
    logic [CROSS_W-1:0]         m_reg;
    logic [2:0]                 cnt_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [1:0]                 comp_reg;
    logic                       go_reg;
    logic signed [NORMAL_W-1:0] res_reg [3];
    logic [1:0]                 sts_reg;
    logic                       m_valid_reg;
    logic signed [NORMAL_W-1:0] nx_reg, ny_reg, nz_reg;
    logic [1:0]                 ost_reg;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [2*MUL_W-1:0]  mul_p;
    logic signed [CROSS_W-1:0]  prod;
    logic                       sqrt_start, sqrt_busy, sqrt_done;
    logic [LEN_W-1:0]           sqrt_root;
    logic                       div_start, div_busy, div_done;
    logic signed [NORMAL_W-1:0] div_normal;
    logic                       out_load;

    assign s_acc   = s_valid && s_ready;
    assign slot_ok = 32'(s_vertex_slot) < VERTEX_DEPTH;
    assign idx_bad = (s_index_a == 16'd0) || (s_index_b == 16'd0) || (s_index_c == 16'd0)
                  || (32'(s_index_a) > VERTEX_DEPTH) || (32'(s_index_b) > VERTEX_DEPTH)
                  || (32'(s_index_c) > VERTEX_DEPTH);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    tfn_ram #(
        .WIDTH (3 * COORD_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_store (
        .aclk      (aclk),
        .we        (s_acc && s_op == OP_WRITE && slot_ok),
        .waddr     (AW'(s_vertex_slot)),
        .wdata     ({s_coord_x, s_coord_y, s_coord_z}),
        .raddr     (rd_addr),
        .rdata_reg (rdata)
    );

    assign rd_x = rdata[3*COORD_W-1:2*COORD_W];
    assign rd_y = rdata[2*COORD_W-1:COORD_W];
    assign rd_z = rdata[COORD_W-1:0];

    tfn_mul u_mul (
        .aclk  (aclk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    assign prod = mul_p[CROSS_W-1:0];

    tfn_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .sum     (sum_reg),
        .busy    (sqrt_busy),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    tfn_div #(
        .FRAC (NORMAL_FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (mag_reg[comp_reg][MAG_W-1:0]),
        .len     (len_reg),
        .neg     (neg_reg[comp_reg]),
        .busy    (div_busy),
        .done    (div_done),
        .normal  (div_normal)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_op == OP_WRITE || idx_bad) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RD_A;
                    end
                end
            end
            ST_RD_A: state_next = ST_RD_B;
            ST_RD_B: state_next = ST_RD_C;
            ST_RD_C: state_next = ST_LAT;
            ST_LAT:  state_next = ST_MUL;
            ST_MUL:  if (cnt_reg == 3'd6) state_next = ST_MAG;
            ST_MAG:  state_next = ST_MAX;
            ST_MAX:  state_next = ST_NORM;
            ST_NORM: begin
                if (m_reg == '0) begin
                    state_next = ST_DONE;
                end else if (m_reg < (CROSS_W'(1) << 30) && m_reg >= (CROSS_W'(1) << 29)) begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR:  if (cnt_reg == 3'd3) state_next = ST_SQRT;
            ST_SQRT: if (sqrt_done) state_next = ST_DIV;
            ST_DIV:  if (div_done && comp_reg == 2'd2) state_next = ST_DONE;
            ST_DONE: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        rd_addr    = ia_reg;
        mul_a      = '0;
        mul_b      = '0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_RD_B: rd_addr = ib_reg;
            ST_RD_C: rd_addr = ic_reg;
            ST_MUL: begin
                unique case (cnt_reg)
                    3'd0: begin mul_a = MUL_W'(uy_reg); mul_b = MUL_W'(vz_reg); end
                    3'd1: begin mul_a = MUL_W'(uz_reg); mul_b = MUL_W'(vy_reg); end
                    3'd2: begin mul_a = MUL_W'(uz_reg); mul_b = MUL_W'(vx_reg); end
                    3'd3: begin mul_a = MUL_W'(ux_reg); mul_b = MUL_W'(vz_reg); end
                    3'd4: begin mul_a = MUL_W'(ux_reg); mul_b = MUL_W'(vy_reg); end
                    3'd5: begin mul_a = MUL_W'(uy_reg); mul_b = MUL_W'(vx_reg); end
                    default: ;
                endcase
            end
            ST_SQR: begin
                if (cnt_reg < 3'd3) begin
                    mul_a = signed'({2'b00, mag_reg[cnt_reg[1:0]][MAG_W-1:0]});
                    mul_b = mul_a;
                end
            end
            ST_SQRT: sqrt_start = !go_reg;
            ST_DIV:  div_start  = !go_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            go_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if ((sqrt_start && !sqrt_busy) || (div_start && !div_busy)) begin
                go_reg <= 1'b1;
            end else if (sqrt_done || div_done) begin
                go_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                ia_reg   <= AW'(s_index_a - 16'd1);
                ib_reg   <= AW'(s_index_b - 16'd1);
                ic_reg   <= AW'(s_index_c - 16'd1);
                res_reg  <= '{default: '0};
                sts_reg  <= (s_op == OP_FACE && idx_bad) ? STATUS_RANGE : STATUS_DONE;
                comp_reg <= '0;
            end
            ST_RD_B: begin
                ax_reg <= rd_x;
                ay_reg <= rd_y;
                az_reg <= rd_z;
            end
            ST_RD_C: begin
                ux_reg <= DIFF_W'(rd_x) - DIFF_W'(ax_reg);
                uy_reg <= DIFF_W'(rd_y) - DIFF_W'(ay_reg);
                uz_reg <= DIFF_W'(rd_z) - DIFF_W'(az_reg);
            end
            ST_LAT: begin
                vx_reg  <= DIFF_W'(rd_x) - DIFF_W'(ax_reg);
                vy_reg  <= DIFF_W'(rd_y) - DIFF_W'(ay_reg);
                vz_reg  <= DIFF_W'(rd_z) - DIFF_W'(az_reg);
                cnt_reg <= '0;
            end
            ST_MUL: begin
                cnt_reg <= cnt_reg + 3'd1;
                // product of the operands issued in the previous cycle
                unique case (cnt_reg)
                    3'd1: c_reg[0] <= prod;
                    3'd2: c_reg[0] <= c_reg[0] - prod;
                    3'd3: c_reg[1] <= prod;
                    3'd4: c_reg[1] <= c_reg[1] - prod;
                    3'd5: c_reg[2] <= prod;
                    3'd6: c_reg[2] <= c_reg[2] - prod;
                    default: ;
                endcase
            end
            ST_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    neg_reg[i] <= c_reg[i][CROSS_W-1];
                    mag_reg[i] <= c_reg[i][CROSS_W-1] ? CROSS_W'(-c_reg[i])
                                                       : CROSS_W'(c_reg[i]);
                end
            end
            ST_MAX: begin
                if (mag_reg[0] >= mag_reg[1] && mag_reg[0] >= mag_reg[2]) begin
                    m_reg <= mag_reg[0];
                end else if (mag_reg[1] >= mag_reg[2]) begin
                    m_reg <= mag_reg[1];
                end else begin
                    m_reg <= mag_reg[2];
                end
            end
            ST_NORM: begin
                cnt_reg <= '0;
                if (m_reg == '0) begin
                    sts_reg <= STATUS_DEGEN;
                end else if (m_reg >= (CROSS_W'(1) << 30)) begin
                    m_reg <= m_reg >> 1;
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end else if (m_reg < (CROSS_W'(1) << 29)) begin
                    m_reg <= m_reg << 1;
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                end
            end
            ST_SQR: begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd1) begin
                    sum_reg <= mul_p[SUM_W-1:0];
                end else if (cnt_reg != 3'd0) begin
                    sum_reg <= sum_reg + mul_p[SUM_W-1:0];
                end
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    len_reg <= sqrt_root;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_reg[comp_reg] <= div_normal;
                    comp_reg          <= comp_reg + 2'd1;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    nx_reg  <= res_reg[0];
                    ny_reg  <= res_reg[1];
                    nz_reg  <= res_reg[2];
                    ost_reg <= sts_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_normal_x = nx_reg;
    assign m_normal_y = ny_reg;
    assign m_normal_z = nz_reg;
    assign m_status   = ost_reg;

endmodule

[rtl/tfn_checker.sv]
// Port-level checks for the face normal block, bound to the top level.
`timescale 1ns / 1ps
module tfn_checker
    import tfn_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [NORMAL_W-1:0] m_normal_x,
    input logic signed [NORMAL_W-1:0] m_normal_y,
    input logic signed [NORMAL_W-1:0] m_normal_z,
    input logic [1:0]                 m_status
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_normal_x) && $stable(m_normal_y)
                                && $stable(m_normal_z) && $stable(m_status))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != STATUS_UNUSED)
        else $error("unused status code");

    // flagged faces carry a zero normal
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_DONE |->
            m_normal_x == '0 && m_normal_y == '0 && m_normal_z == '0)
        else $error("non-zero normal on flagged result");

    // one item at a time: taking a transaction drops ready
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);
